// ===== rtl/bte_pkg.sv =====
// Shared types, constants and text tables for the BASIC token expander.
`timescale 1ns / 1ps

package bte_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int TOK_BYTES   = 11;

    localparam logic [2:0] FMT_NONE  = 3'd0;
    localparam logic [2:0] FMT_BRACE = 3'd1;
    localparam logic [2:0] FMT_HASH  = 3'd2;
    localparam logic [2:0] FMT_ATTR  = 3'd3;
    localparam logic [2:0] FMT_CHR   = 3'd4;

    localparam logic [7:0] CODE_SKIP5  = 8'd14;
    localparam logic [7:0] CODE_COL_LO = 8'd16;
    localparam logic [7:0] CODE_COL_HI = 8'd21;
    localparam logic [7:0] CODE_AT     = 8'd22;
    localparam logic [7:0] CODE_TAB    = 8'd23;
    localparam logic [7:0] CODE_BSLASH = 8'd92;
    localparam logic [7:0] CODE_DEL    = 8'd127;
    localparam logic [7:0] CODE_SPACE  = 8'd32;
    localparam logic [7:0] CODE_TOKEN  = 8'd128;
    localparam logic [7:0] COLOUR_BASE = 8'd15;

    typedef enum logic [1:0] {
        JOB_CHAR,
        JOB_ESC,
        JOB_TOKEN,
        JOB_COLOUR
    } job_kind_t;

    // One expansion job handed from the front to the back
    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  code;
        logic [2:0]  sel;
        logic [7:0]  parm;
        logic [2:0]  fmt;
        logic [4:0]  start;
        logic [4:0]  len;
    } job_t;

    // Keyword and graphic escape text, right-justified, zero-padded
    function automatic logic [8*TOK_BYTES-1:0] tok_str(input logic [6:0] idx);
        case (idx)
            7'd0:   return "\\  ";
            7'd1:   return "\\ '";
            7'd2:   return "\\' ";
            7'd3:   return "\\''";
            7'd4:   return "\\ .";
            7'd5:   return "\\ :";
            7'd6:   return "\\'.";
            7'd7:   return "\\':";
            7'd8:   return "\\. ";
            7'd9:   return "\\.'";
            7'd10:  return "\\: ";
            7'd11:  return "\\:'";
            7'd12:  return "\\..";
            7'd13:  return "\\.:";
            7'd14:  return "\\:.";
            7'd15:  return "\\::";
            7'd16:  return "\\a";
            7'd17:  return "\\b";
            7'd18:  return "\\c";
            7'd19:  return "\\d";
            7'd20:  return "\\e";
            7'd21:  return "\\f";
            7'd22:  return "\\g";
            7'd23:  return "\\h";
            7'd24:  return "\\i";
            7'd25:  return "\\j";
            7'd26:  return "\\k";
            7'd27:  return "\\l";
            7'd28:  return "\\m";
            7'd29:  return "\\n";
            7'd30:  return "\\o";
            7'd31:  return "\\p";
            7'd32:  return "\\q";
            7'd33:  return "\\r";
            7'd34:  return "\\s";
            7'd35:  return "\\t";
            7'd36:  return "\\u";
            7'd37:  return "RND";
            7'd38:  return "INKEY$";
            7'd39:  return "PI";
            7'd40:  return "FN ";
            7'd41:  return "POINT ";
            7'd42:  return "SCREEN$ ";
            7'd43:  return "ATTR ";
            7'd44:  return "AT ";
            7'd45:  return "TAB ";
            7'd46:  return "VAL$ ";
            7'd47:  return "CODE ";
            7'd48:  return "VAL ";
            7'd49:  return "LEN ";
            7'd50:  return "SIN ";
            7'd51:  return "COS ";
            7'd52:  return "TAN ";
            7'd53:  return "ASN ";
            7'd54:  return "ACS ";
            7'd55:  return "ATN ";
            7'd56:  return "LN ";
            7'd57:  return "EXP ";
            7'd58:  return "INT ";
            7'd59:  return "SQR ";
            7'd60:  return "SGN ";
            7'd61:  return "ABS ";
            7'd62:  return "PEEK ";
            7'd63:  return "IN ";
            7'd64:  return "USR ";
            7'd65:  return "STR$ ";
            7'd66:  return "CHR$ ";
            7'd67:  return "NOT ";
            7'd68:  return "BIN ";
            7'd69:  return " OR ";
            7'd70:  return " AND ";
            7'd71:  return "<=";
            7'd72:  return ">=";
            7'd73:  return "<>";
            7'd74:  return " LINE ";
            7'd75:  return " THEN ";
            7'd76:  return " TO ";
            7'd77:  return " STEP ";
            7'd78:  return " DEF FN ";
            7'd79:  return " CAT ";
            7'd80:  return " FORMAT ";
            7'd81:  return " MOVE ";
            7'd82:  return " ERASE ";
            7'd83:  return " OPEN #";
            7'd84:  return " CLOSE #";
            7'd85:  return " MERGE ";
            7'd86:  return " VERIFY ";
            7'd87:  return " BEEP ";
            7'd88:  return " CIRCLE ";
            7'd89:  return " INK ";
            7'd90:  return " PAPER ";
            7'd91:  return " FLASH ";
            7'd92:  return " BRIGHT ";
            7'd93:  return " INVERSE ";
            7'd94:  return " OVER ";
            7'd95:  return " OUT ";
            7'd96:  return " LPRINT ";
            7'd97:  return " LLIST ";
            7'd98:  return " STOP ";
            7'd99:  return " READ ";
            7'd100: return " DATA ";
            7'd101: return " RESTORE ";
            7'd102: return " NEW ";
            7'd103: return " BORDER ";
            7'd104: return " CONTINUE ";
            7'd105: return " DIM ";
            7'd106: return " REM ";
            7'd107: return " FOR ";
            7'd108: return " GO TO ";
            7'd109: return " GO SUB ";
            7'd110: return " INPUT ";
            7'd111: return " LOAD ";
            7'd112: return " LIST ";
            7'd113: return " LET ";
            7'd114: return " PAUSE ";
            7'd115: return " NEXT ";
            7'd116: return " POKE ";
            7'd117: return " PRINT ";
            7'd118: return " PLOT ";
            7'd119: return " RUN ";
            7'd120: return " SAVE ";
            7'd121: return " RANDOMIZE ";
            7'd122: return " IF ";
            7'd123: return " CLS ";
            7'd124: return " DRAW ";
            7'd125: return " CLEAR ";
            7'd126: return " RETURN ";
            7'd127: return " COPY ";
            default: return "";
        endcase
    endfunction

    // Count of characters in a token string
    function automatic logic [3:0] tok_len(input logic [6:0] idx);
        logic [8*TOK_BYTES-1:0] s;
        logic [3:0] n;
        s = tok_str(idx);
        n = 4'd0;
        for (int i = 0; i < TOK_BYTES; i++) begin
            if (s[i*8 +: 8] != 8'd0) begin
                n = n + 4'd1;
            end
        end
        return n;
    endfunction

    // Character at position pos of a token string
    function automatic logic [7:0] tok_char(input logic [6:0] idx, input logic [4:0] pos);
        logic [8*TOK_BYTES-1:0] s;
        logic [3:0] l;
        logic [6:0] sh;
        s  = tok_str(idx);
        l  = tok_len(idx);
        sh = {4'(l - 4'd1 - pos[3:0]), 3'b000};
        return s[sh +: 8];
    endfunction

    // Length of a colour escape in the given format, zero when dropped
    function automatic logic [4:0] colour_len(input logic [2:0] fmt);
        case (fmt)
            FMT_BRACE: return 5'd9;
            FMT_HASH:  return 5'd10;
            FMT_ATTR:  return 5'd5;
            FMT_CHR:   return 5'd18;
            default:   return 5'd0;
        endcase
    endfunction

    // Character at position pos of a colour escape
    function automatic logic [7:0] colour_char(input logic [2:0] fmt, input logic [2:0] sel,
                                               input logic [7:0] parm, input logic [4:0] pos);
        logic [2:0] k;
        logic [7:0] tens;
        logic [7:0] unit;
        logic [7:0] letter;
        logic [7:0] d;
        logic [7:0] c;
        k    = sel - 3'd1;
        tens = (k < 3'd4) ? "1" : "2";
        d    = parm + 8'd48;
        case (k)
            3'd0:    begin unit = "6"; letter = "i"; end
            3'd1:    begin unit = "7"; letter = "p"; end
            3'd2:    begin unit = "8"; letter = "f"; end
            3'd3:    begin unit = "9"; letter = "b"; end
            3'd4:    begin unit = "0"; letter = "v"; end
            default: begin unit = "1"; letter = "o"; end
        endcase
        c = 8'd0;
        case (fmt)
            FMT_BRACE: begin
                case (pos)
                    5'd0, 5'd5: c = "\\";
                    5'd1, 5'd6: c = "{";
                    5'd2:       c = tens;
                    5'd3:       c = unit;
                    5'd7:       c = d;
                    default:    c = "}";
                endcase
            end
            FMT_HASH: begin
                case (pos)
                    5'd0, 5'd5: c = "\\";
                    5'd1, 5'd6: c = "#";
                    5'd3:       c = tens;
                    5'd4:       c = unit;
                    5'd9:       c = d;
                    default:    c = "0";
                endcase
            end
            FMT_ATTR: begin
                case (pos)
                    5'd0:    c = "\\";
                    5'd1:    c = "{";
                    5'd2:    c = letter;
                    5'd3:    c = (k == 3'd4) ? ((parm != 8'd0) ? "i" : "n") : d;
                    default: c = "}";
                endcase
            end
            FMT_CHR: begin
                case (pos)
                    5'd0, 5'd17:        c = "\"";
                    5'd1, 5'd9, 5'd16:  c = ";";
                    5'd2, 5'd10:        c = "C";
                    5'd3, 5'd11:        c = "H";
                    5'd4, 5'd12:        c = "R";
                    5'd5, 5'd13:        c = "$";
                    5'd6, 5'd14:        c = " ";
                    5'd7:               c = tens;
                    5'd8:               c = unit;
                    default:            c = d;
                endcase
            end
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    // Character at position pos of a job
    function automatic logic [7:0] job_char(input job_t job, input logic [4:0] pos);
        case (job.kind)
            JOB_CHAR:  return job.code;
            JOB_ESC:   return (pos == 5'd0) ? "\\" :
                              ((job.code == CODE_BSLASH) ? "\\" : "*");
            JOB_TOKEN: return tok_char(job.code[6:0], pos);
            default:   return colour_char(job.fmt, job.sel, job.parm, pos);
        endcase
    endfunction

endpackage

// ===== rtl/basic_token_expander_unit.sv =====
// Top level of the BASIC token expander.
//
//  channel   direction  handshake            words
//  input     in         push / full          code_byte, line_end
//  result    out        empty / pop          out_char, run_last
//  config    in         cfg_valid/cfg_ready  colour_format
//
// An accepted byte is classified in its accept cycle and queued as a job when it
// yields text. The back end loads a job, then emits one character per cycle
// while the result is not stalled, and takes the next job only after the last.
// Reset clears line state, the job queue, the format and the result valid flag.
// A stalled result holds; input stalls only when the job queue is full.
`timescale 1ns / 1ps

module basic_token_expander_unit
#(
    parameter int QUEUE_DEPTH = bte_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  code_byte,
    input  logic        line_end,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_char,
    output logic        run_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  colour_format
);

    logic           fmt_wr;
    logic [2:0]     fmt_reg;
    logic           accept;
    logic           fj_valid;
    bte_pkg::job_t  fj;
    logic           q_full;
    logic           q_valid;
    bte_pkg::job_t  q_job;
    logic           q_take;

    assign cfg_ready = 1'b1;
    assign fmt_wr    = cfg_valid && cfg_ready;
    assign full      = q_full;
    assign accept    = push && !q_full;

    // Colour format register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= bte_pkg::FMT_NONE;
        end
        else if (fmt_wr)
        begin
            fmt_reg <= colour_format;
        end
    end

    bte_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .code_byte (code_byte),
        .line_end  (line_end),
        .fmt       (fmt_reg),
        .job_valid (fj_valid),
        .job       (fj)
    );

    bte_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && fj_valid),
        .wr_job   (fj),
        .full     (q_full),
        .rd_en    (q_take),
        .rd_valid (q_valid),
        .rd_job   (q_job)
    );

    bte_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job       (q_job),
        .job_take  (q_take),
        .pop       (pop),
        .empty     (empty),
        .out_char  (out_char),
        .run_last  (run_last)
    );

endmodule

// ===== rtl/bte_front.sv =====
// Front end: accepts code bytes, tracks skip/colour/space state, issues jobs.
`timescale 1ns / 1ps

module bte_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        code_byte,
    input  logic              line_end,
    input  logic [2:0]        fmt,
    output logic              job_valid,
    output bte_pkg::job_t     job
);

    logic [2:0] skip_reg, skip_next;
    logic [2:0] pend_reg, pend_next;
    logic       space_reg, space_next;
    logic [7:0] last_ch;

    // Classify the byte and work out the next line state
    always_comb
    begin
        job        = '0;
        job.fmt    = fmt;
        job.code   = code_byte;
        job_valid  = 1'b0;
        last_ch    = 8'd0;
        skip_next  = skip_reg;
        pend_next  = pend_reg;
        space_next = space_reg;

        if (skip_reg != 3'd0)
        begin
            skip_next = skip_reg - 3'd1;
        end
        else if (pend_reg != 3'd0)
        begin
            job.kind  = bte_pkg::JOB_COLOUR;
            job.sel   = pend_reg;
            job.parm  = code_byte;
            job.len   = bte_pkg::colour_len(fmt);
            job_valid = (job.len != 5'd0);
            pend_next = 3'd0;
        end
        else if (code_byte == bte_pkg::CODE_SKIP5)
        begin
            skip_next = 3'd5;
        end
        else if (code_byte == bte_pkg::CODE_AT || code_byte == bte_pkg::CODE_TAB)
        begin
            skip_next = 3'd2;
        end
        else if (code_byte >= bte_pkg::CODE_COL_LO && code_byte <= bte_pkg::CODE_COL_HI)
        begin
            if (line_end)
            begin
                job.kind  = bte_pkg::JOB_COLOUR;
                job.sel   = 3'(code_byte - bte_pkg::COLOUR_BASE);
                job.parm  = 8'd0;
                job.len   = bte_pkg::colour_len(fmt);
                job_valid = (job.len != 5'd0);
            end
            else
            begin
                pend_next = 3'(code_byte - bte_pkg::COLOUR_BASE);
            end
        end
        else if (code_byte == bte_pkg::CODE_BSLASH || code_byte == bte_pkg::CODE_DEL)
        begin
            job.kind  = bte_pkg::JOB_ESC;
            job.len   = 5'd2;
            job_valid = 1'b1;
        end
        else if (code_byte >= bte_pkg::CODE_TOKEN)
        begin
            job.kind  = bte_pkg::JOB_TOKEN;
            job.len   = {1'b0, bte_pkg::tok_len(code_byte[6:0])};
            // leading space dropped after a space
            job.start = {4'd0, space_reg &&
                        (bte_pkg::tok_char(code_byte[6:0], 5'd0) == bte_pkg::CODE_SPACE)};
            job_valid = 1'b1;
        end
        else if (code_byte >= bte_pkg::CODE_SPACE)
        begin
            job.kind  = bte_pkg::JOB_CHAR;
            job.len   = 5'd1;
            job_valid = 1'b1;
        end

        // space tracking from the final character of the run
        if (job_valid)
        begin
            last_ch    = bte_pkg::job_char(job, job.len - 5'd1);
            space_next = (last_ch == bte_pkg::CODE_SPACE);
        end

        if (line_end)
        begin
            skip_next  = 3'd0;
            pend_next  = 3'd0;
            space_next = 1'b0;
        end
    end

    // Line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg  <= 3'd0;
            pend_reg  <= 3'd0;
            space_reg <= 1'b0;
        end
        else if (accept)
        begin
            skip_reg  <= skip_next;
            pend_reg  <= pend_next;
            space_reg <= space_next;
        end
    end

endmodule

// ===== rtl/bte_queue.sv =====
// Short job queue between front and back ends.
`timescale 1ns / 1ps

module bte_queue
#(
    parameter int DEPTH = bte_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  bte_pkg::job_t     wr_job,
    output logic              full,
    input  logic              rd_en,
    output logic              rd_valid,
    output bte_pkg::job_t     rd_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bte_pkg::job_t  slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = slot_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Job storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// ===== rtl/bte_back.sv =====
// Back end: walks a job one character per cycle into the result register while it is not stalled.
`timescale 1ns / 1ps

module bte_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  bte_pkg::job_t     job,
    output logic              job_take,
    input  logic              pop,
    output logic              empty,
    output logic [7:0]        out_char,
    output logic              run_last
);

    bte_pkg::job_t job_reg;
    logic          busy_reg;
    logic [4:0]    pos_reg;
    logic          ovalid_reg;
    logic [7:0]    char_reg, char_next;
    logic          last_reg, last_next;
    logic          emit;

    assign job_take  = !busy_reg && job_valid;
    assign emit      = busy_reg && (!ovalid_reg || pop);
    assign char_next = bte_pkg::job_char(job_reg, pos_reg);
    assign last_next = (pos_reg == job_reg.len - 5'd1);

    assign empty    = !ovalid_reg;
    assign out_char = char_reg;
    assign run_last = last_reg;

    // Sequencer control and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            pos_reg    <= 5'd0;
        end
        else
        begin
            if (job_take)
            begin
                busy_reg <= 1'b1;
                pos_reg  <= job.start;
            end
            else if (emit)
            begin
                pos_reg <= pos_reg + 5'd1;
                if (last_next)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (pop)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            job_reg <= job;
        end
        if (emit)
        begin
            char_reg <= char_next;
            last_reg <= last_next;
        end
    end

endmodule

// ===== rtl/bte_checker.sv =====
// Port-level checks for the BASIC token expander, bound to the top level.
`timescale 1ns / 1ps

module bte_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        full,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  out_char,
    input  logic        run_last
);

    // Reset leaves no result and room for input
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> empty && !full)
        else $error("not idle after reset");

    // A stalled result stays
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result dropped while stalled");

    // A stalled result keeps its value
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(out_char) && $stable(run_last))
        else $error("result changed while stalled");

    // Inside a run the next character follows at once
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !run_last |=> !empty)
        else $error("gap inside a run");

endmodule

bind basic_token_expander_unit bte_checker u_bte_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .out_char (out_char),
    .run_last (run_last)
);

// ===== tb/testbench.sv =====
// Testbench for the BASIC token expander: directed and random byte streams checked per character.
`timescale 1ns / 1ps

module testbench;

    localparam int STALL_LIMIT = 4000;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] code_byte;
    logic       line_end;
    logic       empty;
    logic       pop;
    logic [7:0] out_char;
    logic       run_last;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] colour_format;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_word_t;

    // model state
    logic [2:0] fmt_reg;
    logic [2:0] skip_cnt;
    logic [2:0] colour_sel;
    logic       last_space;

    char_word_t pending_chars[$];
    int         err_count;
    int         idle_cycles;
    bit         pop_enable;

    basic_token_expander_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .code_byte     (code_byte),
        .line_end      (line_end),
        .empty         (empty),
        .pop           (pop),
        .out_char      (out_char),
        .run_last      (run_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .colour_format (colour_format)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // keyword and graphic text by token index
    function automatic string token_text(input int idx);
        string t[128] = '{
            "\\  ", "\\ '", "\\' ", "\\''", "\\ .", "\\ :", "\\'.", "\\':",
            "\\. ", "\\.'", "\\: ", "\\:'", "\\..", "\\.:", "\\:.", "\\::",
            "\\a", "\\b", "\\c", "\\d", "\\e", "\\f", "\\g", "\\h", "\\i", "\\j",
            "\\k", "\\l", "\\m", "\\n", "\\o", "\\p", "\\q", "\\r", "\\s", "\\t",
            "\\u",
            "RND", "INKEY$", "PI", "FN ", "POINT ", "SCREEN$ ", "ATTR ", "AT ",
            "TAB ", "VAL$ ", "CODE ", "VAL ", "LEN ", "SIN ", "COS ", "TAN ",
            "ASN ", "ACS ", "ATN ", "LN ", "EXP ", "INT ", "SQR ", "SGN ",
            "ABS ", "PEEK ", "IN ", "USR ", "STR$ ", "CHR$ ", "NOT ", "BIN ",
            " OR ", " AND ", "<=", ">=", "<>", " LINE ", " THEN ", " TO ",
            " STEP ", " DEF FN ", " CAT ", " FORMAT ", " MOVE ", " ERASE ",
            " OPEN #", " CLOSE #", " MERGE ", " VERIFY ", " BEEP ", " CIRCLE ",
            " INK ", " PAPER ", " FLASH ", " BRIGHT ", " INVERSE ", " OVER ",
            " OUT ", " LPRINT ", " LLIST ", " STOP ", " READ ", " DATA ",
            " RESTORE ", " NEW ", " BORDER ", " CONTINUE ", " DIM ", " REM ",
            " FOR ", " GO TO ", " GO SUB ", " INPUT ", " LOAD ", " LIST ",
            " LET ", " PAUSE ", " NEXT ", " POKE ", " PRINT ", " PLOT ",
            " RUN ", " SAVE ", " RANDOMIZE ", " IF ", " CLS ", " DRAW ",
            " CLEAR ", " RETURN ", " COPY "
        };
        return t[idx];
    endfunction

    // colour escape text for control select 1..6 and parameter p
    function automatic string colour_text(input logic [2:0] sel, input logic [7:0] p);
        string      units;
        string      letters;
        string      s;
        string      v;
        logic [7:0] tens;
        logic [7:0] d;
        int         k;
        units   = "678901";
        letters = "ipfbvo";
        k       = sel - 1;
        tens    = (k < 4) ? "1" : "2";
        d       = p + 8'd48;
        s       = "";
        // attribute form uses i/n for the inverse control
        v       = string'(d);
        if (k == 4)
            v = (p != 0) ? "i" : "n";
        case (fmt_reg)
            bte_pkg::FMT_BRACE: s = {"\\{", string'(tens), string'(units[k]), "}\\{",
                                     string'(d), "}"};
            bte_pkg::FMT_HASH:  s = {"\\#0", string'(tens), string'(units[k]), "\\#00",
                                     string'(d)};
            bte_pkg::FMT_ATTR:  s = {"\\{", string'(letters[k]), v, "}"};
            bte_pkg::FMT_CHR:   s = {"\";CHR$ ", string'(tens), string'(units[k]), ";CHR$ ",
                                     string'(d), ";\""};
            default:            s = "";
        endcase
        return s;
    endfunction

    // expand one accepted byte into expected characters
    task automatic expand_byte(input logic [7:0] b, input logic eol);
        string s;
        bit    trim;
        char_word_t w;
        s    = "";
        trim = 1'b1;
        if (skip_cnt != 0) begin
            skip_cnt = skip_cnt - 1;
        end else if (colour_sel != 0) begin
            s          = colour_text(colour_sel, b);
            colour_sel = 0;
        end else if (b == bte_pkg::CODE_SKIP5) begin
            skip_cnt = 5;
        end else if (b == bte_pkg::CODE_AT || b == bte_pkg::CODE_TAB) begin
            skip_cnt = 2;
        end else if (b >= bte_pkg::CODE_COL_LO && b <= bte_pkg::CODE_COL_HI) begin
            if (eol)
                s = colour_text(3'(b - bte_pkg::COLOUR_BASE), 8'd0);
            else
                colour_sel = 3'(b - bte_pkg::COLOUR_BASE);
        end else if (b == bte_pkg::CODE_BSLASH) begin
            s = "\\\\";
        end else if (b == bte_pkg::CODE_DEL) begin
            s = "\\*";
        end else if (b >= bte_pkg::CODE_TOKEN) begin
            s = token_text(b - bte_pkg::CODE_TOKEN);
        end else if (b >= bte_pkg::CODE_SPACE) begin
            s    = string'(b);
            trim = 1'b0;
        end
        if (trim && s.len() > 0 && last_space && s[0] == " ")
            s = s.substr(1, s.len() - 1);
        for (int i = 0; i < s.len(); i++) begin
            w.ch   = s[i];
            w.last = (i == s.len() - 1);
            pending_chars.push_back(w);
        end
        if (s.len() > 0)
            last_space = (s[s.len() - 1] == " ");
        if (eol) begin
            skip_cnt   = 0;
            colour_sel = 0;
            last_space = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        err_count++;
    endtask

    function automatic int rand_gap();
        if ($urandom_range(0, 9) < 7)
            return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        return $urandom_range(4, 30);
    endfunction

    // send one byte; waits for acceptance, push stays up for a following byte
    task automatic send_byte(input logic [7:0] b, input logic eol, input bit gaps);
        int gap;
        gap = gaps ? rand_gap() : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push      <= 1'b1;
        code_byte <= b;
        line_end  <= eol;
        do @(posedge clk); while (full);
        expand_byte(b, eol);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (pending_chars.size() != 0) @(negedge clk);
        repeat (25) @(negedge clk);
    endtask

    task automatic write_format(input logic [2:0] f);
        wait_drained();
        cfg_valid     <= 1'b1;
        colour_format <= f;
        do @(posedge clk); while (!cfg_ready);
        fmt_reg = f;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // pop side with random stalls
    initial
    begin
        int stall;
        pop = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!pop_enable) begin
                pop <= 1'b0;
            end else begin
                stall = rand_gap();
                if (stall > 0) begin
                    pop <= 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end else begin
                    pop <= 1'b1;
                end
            end
        end
    end

    // result checker and stall watchdog
    always @(posedge clk)
    begin
        char_word_t w;
        if (rst_n) begin
            idle_cycles <= ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                           ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
            if (pop && !empty) begin
                if (pending_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected char %h", out_char));
                end else begin
                    w = pending_chars.pop_front();
                    if (out_char !== w.ch)
                        report_mismatch($sformatf("out_char %h, want %h", out_char, w.ch));
                    if (run_last !== w.last)
                        report_mismatch($sformatf("run_last %b, want %b on %h",
                                                  run_last, w.last, w.ch));
                end
            end
        end
    end

    task automatic test_plain_and_escapes();
        logic [7:0] bytes[$] = '{8'd0, 8'd31, 8'd32, 8'd65, 8'd92, 8'd126, 8'd127,
                                 8'd128, 8'd143, 8'd144, 8'd164, 8'd165, 8'd249,
                                 8'd197, 8'd255};
        foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1, 1'b0);
    endtask

    // skip codes, colour codes mid line and at line end, space trimming
    task automatic test_controls();
        send_byte(bte_pkg::CODE_SKIP5, 0, 0);
        repeat (5) send_byte(8'd200, 0, 0);
        send_byte(bte_pkg::CODE_AT, 0, 0);
        send_byte(8'd16, 0, 0);
        send_byte(8'd17, 0, 0);
        send_byte(8'd20, 0, 0);
        send_byte(8'd255, 0, 0);
        send_byte(8'd20, 0, 0);
        send_byte(8'd0, 0, 0);
        send_byte(8'd32, 0, 0);
        send_byte(8'd197, 0, 0);
        send_byte(8'd21, 1, 0);
        send_byte(bte_pkg::CODE_TAB, 1, 0);
    endtask

    // mostly well-formed lines with random content
    task automatic test_random_lines(input int n_items);
        int         sent;
        int         len;
        int         r;
        logic [7:0] b;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len && sent < n_items; i++) begin
                r = $urandom_range(0, 99);
                if (r < 30)      b = $urandom_range(165, 255);
                else if (r < 45) b = $urandom_range(128, 164);
                else if (r < 65) b = $urandom_range(32, 127);
                else if (r < 80) b = $urandom_range(16, 21);
                else if (r < 88) b = ($urandom_range(0, 2) == 0) ? bte_pkg::CODE_SKIP5
                                     : $urandom_range(22, 23);
                else             b = $urandom_range(0, 255);
                send_byte(b, i == len - 1, 1'b1);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        push          = 1'b0;
        code_byte     = 8'd0;
        line_end      = 1'b0;
        cfg_valid     = 1'b0;
        colour_format = bte_pkg::FMT_NONE;
        pop_enable    = 1'b1;
        err_count     = 0;
        idle_cycles   = 0;
        fmt_reg       = bte_pkg::FMT_NONE;
        skip_cnt      = 0;
        colour_sel    = 0;
        last_space    = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_plain_and_escapes();
        test_controls();
        for (int f = 1; f <= 7; f++) begin
            write_format(3'(f));
            test_controls();
            test_random_lines(9);
        end
        write_format(bte_pkg::FMT_CHR);
        test_random_lines(40);
        write_format(bte_pkg::FMT_NONE);
        test_random_lines(20);

        wait_drained();
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bte_pkg.sv
rtl/bte_front.sv
rtl/bte_queue.sv
rtl/bte_back.sv
rtl/basic_token_expander_unit.sv
rtl/bte_checker.sv
tb/testbench.sv
